// ===== hw/rtl/clsp_pkg.sv =====
// ----------------------------------------------------------------------------
// clsp_pkg
// Shared constants, codes and controller/datapath interface types for the
// cache lookup block with stream prefetch.
// ----------------------------------------------------------------------------
package clsp_pkg;

   // default geometry, handed to the top level parameters
   localparam int unsigned SETS_DEF       = 16;
   localparam int unsigned WAYS_DEF       = 8;
   localparam int unsigned PREFETCH_DEF   = 4;
   localparam int unsigned ADDR_WIDTH_DEF = 32;

   // fixed field widths
   localparam int unsigned REQ_ADDR_W  = 32;
   localparam int unsigned META_W      = 32;
   localparam int unsigned CNT_W       = 32;
   localparam int unsigned LFSR_W      = 16;
   localparam int unsigned FILLS_W     = 3;
   localparam int unsigned SET_COUNT_W = 5;
   localparam int unsigned WAY_COUNT_W = 4;
   localparam int unsigned POLICY_W    = 3;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REG_IDX_W   = 2;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   // replacement policy codes
   localparam logic [POLICY_W-1:0] POL_RANDOM = 3'd0;
   localparam logic [POLICY_W-1:0] POL_LRU    = 3'd1;
   localparam logic [POLICY_W-1:0] POL_LFU    = 3'd2;
   localparam logic [POLICY_W-1:0] POL_FIFO   = 3'd3;
   localparam logic [POLICY_W-1:0] POL_LIFO   = 3'd4;
   localparam logic [POLICY_W-1:0] POL_MRU    = 3'd5;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_SET_COUNT = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WAY_COUNT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_POLICY    = 2'd2;

   localparam logic [SET_COUNT_W-1:0] SET_COUNT_RST = 5'd1;
   localparam logic [WAY_COUNT_W-1:0] WAY_COUNT_RST = 4'd8;
   localparam logic [POLICY_W-1:0]    POLICY_RST    = POL_RANDOM;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic lookup_rd;
      logic compare;
      logic scan;
      logic fill;
      logic advance;
      logic finish;
   } clsp_cmd_type;

   typedef struct packed {
      logic mod_last;
      logic hit;
      logic first;
      logic last;
      logic fill_rand;
      logic fill_scan;
      logic fill_direct;
      logic scan_end;
      logic out_free;
   } clsp_stat_type;

endpackage

// ===== hw/rtl/clsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// clsp_ctrl
// Sequencer: steps one access through set index, lookup, victim choice,
// fill and the prefetch walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
module clsp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output clsp_pkg::clsp_cmd_type cmd,
   input  clsp_pkg::clsp_stat_type stat
);
   import clsp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD  = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_CMP  = 4'd3;
   localparam logic [3:0] S_RMOD = 4'd4;
   localparam logic [3:0] S_SCAN = 4'd5;
   localparam logic [3:0] S_FILL = 4'd6;
   localparam logic [3:0] S_NEXT = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = S_RD;
         end
         S_RD: begin
            cmd.lookup_rd = 1'b1;
            state_in      = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            if (stat.hit && stat.first) state_in = S_DONE;
            else if (stat.hit || stat.first) state_in = S_NEXT;
            else if (stat.fill_rand) state_in = S_RMOD;
            else if (stat.fill_scan) state_in = S_SCAN;
            else if (stat.fill_direct) state_in = S_FILL;
            else state_in = S_NEXT;
         end
         S_RMOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_last) state_in = S_FILL;
         end
         S_SCAN: begin
            if (stat.scan_end) state_in = S_FILL;
            else cmd.scan = 1'b1;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (stat.last) begin
               state_in = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_RD;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/clsp_dp.sv =====
// ----------------------------------------------------------------------------
// clsp_dp
// Datapath: line storage (one row per set), valid bits, fill pointers,
// serial remainder unit, victim scan, counters and the output register.
// ----------------------------------------------------------------------------
module clsp_dp #(
   parameter int unsigned SETS           = clsp_pkg::SETS_DEF,
   parameter int unsigned WAYS           = clsp_pkg::WAYS_DEF,
   parameter int unsigned PREFETCH_DEPTH = clsp_pkg::PREFETCH_DEF,
   parameter int unsigned ADDR_WIDTH     = clsp_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clsp_pkg::clsp_cmd_type               cmd,
   output clsp_pkg::clsp_stat_type              stat,
   input  logic                                 cfg_clear,
   input  logic [clsp_pkg::SET_COUNT_W-1:0]     set_count,
   input  logic [clsp_pkg::WAY_COUNT_W-1:0]     way_count,
   input  logic [clsp_pkg::POLICY_W-1:0]        policy,
   input  logic [clsp_pkg::REQ_ADDR_W-1:0]      req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [clsp_pkg::FILLS_W-1:0]         rsp_fills,
   output logic [clsp_pkg::CNT_W-1:0]           rsp_hit_total
);
   import clsp_pkg::*;

   localparam int unsigned SIW        = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int unsigned WIW        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned SCW        = $clog2(SETS + 1);
   localparam int unsigned WCW        = $clog2(WAYS + 1);
   localparam int unsigned MAXD       = (SETS > WAYS) ? SETS : WAYS;
   localparam int unsigned DW         = $clog2(MAXD + 1);
   localparam int unsigned DIGIT_BITS = 8;
   localparam int unsigned OPW        = (ADDR_WIDTH > LFSR_W) ? ADDR_WIDTH : LFSR_W;
   localparam int unsigned MOD_STEPS  = (OPW + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int unsigned MOD_BITS   = MOD_STEPS * DIGIT_BITS;
   localparam int unsigned MCW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int unsigned KW         = $clog2(PREFETCH_DEPTH + 1);
   localparam int unsigned ROW_AW     = WAYS * ADDR_WIDTH;
   localparam int unsigned ROW_MW     = WAYS * META_W;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
      lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
   endfunction

   // line storage, one row per set
   logic [ROW_AW-1:0] addr_mem [SETS];
   logic [ROW_MW-1:0] meta_mem [SETS];
   logic [ROW_AW-1:0] addr_row_ff;
   logic [ROW_MW-1:0] meta_row_ff;

   logic [WAYS-1:0]       valid_ff [SETS];
   logic [WAYS-1:0]       valid_in [SETS];
   logic [WIW-1:0]        ptr_ff [SETS];
   logic [WIW-1:0]        ptr_in [SETS];

   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [SIW-1:0]        set_ff, set_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  hit_ff, hit_in;
   logic [FILLS_W-1:0]    fills_ff, fills_in;
   logic [CNT_W-1:0]      time_ff, time_in;
   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;
   logic [CNT_W-1:0]      hitcnt_ff, hitcnt_in;
   logic [MOD_BITS-1:0]   mod_opnd_ff, mod_opnd_in;
   logic [DW-1:0]         mod_rem_ff, mod_rem_in;
   logic [MCW-1:0]        mod_cnt_ff, mod_cnt_in;
   logic                  mod_ways_ff, mod_ways_in;
   logic [WIW-1:0]        victim_ff, victim_in;
   logic [META_W-1:0]     best_ff, best_in;
   logic [WCW-1:0]        scan_j_ff, scan_j_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [FILLS_W-1:0]    rsp_fills_ff, rsp_fills_in;
   logic [CNT_W-1:0]      rsp_total_ff, rsp_total_in;

   logic [SCW-1:0]        sets_used;
   logic [WCW-1:0]        ways_used;
   logic [DW-1:0]         divisor;
   logic [DW-1:0]         mod_rem_nx;
   logic [ADDR_WIDTH+REQ_ADDR_W-1:0] addr_ext;
   logic [WAYS-1:0]       valid_row;
   logic [META_W-1:0]     meta_eff [WAYS];
   logic [META_W-1:0]     meta_rst;
   logic                  hit_any;
   logic [WIW-1:0]        hit_way;
   logic                  addr_wr_en, meta_wr_en;
   logic [ROW_AW-1:0]     addr_wr_row;
   logic [ROW_MW-1:0]     meta_wr_row;
   logic [WIW-1:0]        victim_sel;
   logic                  mod_last;
   logic                  scan_mru;

   // clamp register values into the built geometry
   always_comb begin
      if (set_count == '0) sets_used = SCW'(1);
      else if (int'(set_count) > SETS) sets_used = SCW'(SETS);
      else sets_used = SCW'(set_count);
      if (way_count == '0) ways_used = WCW'(1);
      else if (int'(way_count) > WAYS) ways_used = WCW'(WAYS);
      else ways_used = WCW'(way_count);
   end

   assign addr_ext = {{ADDR_WIDTH{1'b0}}, req_address};
   assign divisor  = mod_ways_ff ? DW'(ways_used) : DW'(sets_used);
   assign mod_last = (mod_cnt_ff == MCW'(MOD_STEPS - 1));
   assign meta_rst = (policy == POL_MRU) ? '1 : '0;
   assign scan_mru = (policy == POL_MRU);

   // restoring remainder, one byte of the operand per cycle, msb first
   always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      r = mod_rem_ff;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         t = {r, mod_opnd_ff[MOD_BITS-1-i]};
         if (t >= {1'b0, divisor}) t = t - {1'b0, divisor};
         r = t[DW-1:0];
      end
      mod_rem_nx = r;
   end

   // tag compare across the row, first matching way wins
   assign valid_row = valid_ff[set_ff];
   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         meta_eff[w] = valid_row[w] ? meta_row_ff[w*META_W +: META_W] : meta_rst;
         if (valid_row[w] && (w < int'(ways_used)) &&
             (addr_row_ff[w*ADDR_WIDTH +: ADDR_WIDTH] == addr_ff)) begin
            hit_any = 1'b1;
            hit_way = WIW'(w);
         end
      end
   end

   assign victim_sel = (policy == POL_RANDOM) ? WIW'(mod_rem_ff) : victim_ff;

   always_comb begin
      logic [WCW-1:0]    p;
      logic [WCW-1:0]    pn;
      logic [META_W-1:0] m;
      logic [META_W-1:0] cur;
      logic [SCW-1:0]    set_nx;

      addr_in      = addr_ff;
      set_in       = set_ff;
      k_in         = k_ff;
      hit_in       = hit_ff;
      fills_in     = fills_ff;
      time_in      = time_ff;
      lfsr_in      = lfsr_ff;
      hitcnt_in    = hitcnt_ff;
      mod_opnd_in  = mod_opnd_ff;
      mod_rem_in   = mod_rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      mod_ways_in  = mod_ways_ff;
      victim_in    = victim_ff;
      best_in      = best_ff;
      scan_j_in    = scan_j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fills_in = rsp_fills_ff;
      rsp_total_in = rsp_total_ff;
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      addr_wr_en   = 1'b0;
      meta_wr_en   = 1'b0;
      addr_wr_row  = addr_row_ff;
      meta_wr_row  = meta_row_ff;
      p            = '0;
      pn           = '0;
      m            = '0;
      cur          = '0;
      set_nx       = '0;

      if (cmd.load) begin
         addr_in     = addr_ext[ADDR_WIDTH-1:0];
         k_in        = '0;
         hit_in      = 1'b0;
         fills_in    = '0;
         time_in     = time_ff + 1'b1;
         mod_opnd_in = MOD_BITS'(addr_ext[ADDR_WIDTH-1:0]);
         mod_rem_in  = '0;
         mod_cnt_in  = '0;
         mod_ways_in = 1'b0;
      end

      if (cmd.mod_step) begin
         mod_opnd_in = mod_opnd_ff << DIGIT_BITS;
         mod_rem_in  = mod_rem_nx;
         mod_cnt_in  = mod_last ? '0 : mod_cnt_ff + 1'b1;
         if (mod_last && !mod_ways_ff) set_in = SIW'(mod_rem_nx);
      end

      if (cmd.compare) begin
         if (hit_any) begin
            cur = meta_row_ff[hit_way*META_W +: META_W];
            if (policy == POL_LFU) begin
               meta_wr_en = 1'b1;
               meta_wr_row[hit_way*META_W +: META_W] = (cur == '1) ? cur : cur + 1'b1;
            end else if (policy == POL_LRU || policy == POL_MRU) begin
               meta_wr_en = 1'b1;
               meta_wr_row[hit_way*META_W +: META_W] = time_ff;
            end
            if (k_ff == '0) begin
               hit_in = 1'b1;
               if (hitcnt_ff != '1) hitcnt_in = hitcnt_ff + 1'b1;
            end
         end else if (k_ff != '0) begin
            case (policy)
               POL_RANDOM: begin
                  lfsr_in     = lfsr_step(lfsr_ff);
                  mod_opnd_in = MOD_BITS'(lfsr_step(lfsr_ff));
                  mod_rem_in  = '0;
                  mod_cnt_in  = '0;
                  mod_ways_in = 1'b1;
               end
               POL_LRU, POL_LFU, POL_MRU: begin
                  victim_in = '0;
                  best_in   = meta_eff[0];
                  scan_j_in = WCW'(1);
               end
               POL_FIFO: begin
                  p = WCW'(ptr_ff[set_ff]);
                  if (p >= ways_used) p = '0;
                  victim_in = WIW'(p);
                  pn = p + 1'b1;
                  if (pn >= ways_used) pn = '0;
                  ptr_in[set_ff] = WIW'(pn);
               end
               POL_LIFO: begin
                  p = WCW'(ptr_ff[set_ff]);
                  if (p >= ways_used) p = ways_used - 1'b1;
                  victim_in = WIW'(p);
                  pn = p + 1'b1;
                  if (pn >= ways_used) pn = ways_used - 1'b1;
                  ptr_in[set_ff] = WIW'(pn);
               end
               default: begin
                  victim_in = victim_ff;
               end
            endcase
         end
      end

      // victim scan, one way per cycle
      if (cmd.scan) begin
         m = meta_eff[scan_j_ff[WIW-1:0]];
         if (scan_mru ? (m > best_ff) : (m < best_ff)) begin
            victim_in = WIW'(scan_j_ff);
            best_in   = m;
         end
         scan_j_in = scan_j_ff + 1'b1;
      end

      if (cmd.fill) begin
         addr_wr_en = 1'b1;
         addr_wr_row[victim_sel*ADDR_WIDTH +: ADDR_WIDTH] = addr_ff;
         valid_in[set_ff][victim_sel] = 1'b1;
         fills_in = fills_ff + 1'b1;
         if (policy == POL_LRU || policy == POL_MRU) begin
            meta_wr_en = 1'b1;
            meta_wr_row[victim_sel*META_W +: META_W] = time_ff;
         end else if (policy == POL_LFU) begin
            meta_wr_en = 1'b1;
            meta_wr_row[victim_sel*META_W +: META_W] = META_W'(1);
         end
      end

      // next prefetch address; set index +1, wraps on set count or address wrap
      if (cmd.advance) begin
         k_in    = k_ff + 1'b1;
         addr_in = addr_ff + 1'b1;
         set_nx  = SCW'(set_ff) + 1'b1;
         if (addr_in == '0 || set_nx == sets_used) set_in = '0;
         else set_in = SIW'(set_nx);
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_fills_in = fills_ff;
         rsp_total_in = hitcnt_ff;
      end

      if (cfg_clear) begin
         for (int s = 0; s < SETS; s++) begin
            valid_in[s] = '0;
            ptr_in[s]   = '0;
         end
         hitcnt_in = '0;
      end
   end

   // row memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (addr_wr_en) addr_mem[set_ff] <= addr_wr_row;
      if (meta_wr_en) meta_mem[set_ff] <= meta_wr_row;
      if (cmd.lookup_rd) begin
         addr_row_ff <= addr_mem[set_ff];
         meta_row_ff <= meta_mem[set_ff];
      end else if (meta_wr_en) begin
         meta_row_ff <= meta_wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
            ptr_ff[s]   <= '0;
         end
         time_ff      <= '0;
         lfsr_ff      <= LFSR_SEED;
         hitcnt_ff    <= '0;
         mod_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         time_ff      <= time_in;
         lfsr_ff      <= lfsr_in;
         hitcnt_ff    <= hitcnt_in;
         mod_cnt_ff   <= mod_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      set_ff       <= set_in;
      k_ff         <= k_in;
      hit_ff       <= hit_in;
      fills_ff     <= fills_in;
      mod_opnd_ff  <= mod_opnd_in;
      mod_rem_ff   <= mod_rem_in;
      mod_ways_ff  <= mod_ways_in;
      victim_ff    <= victim_in;
      best_ff      <= best_in;
      scan_j_ff    <= scan_j_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fills_ff <= rsp_fills_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign stat.mod_last    = mod_last;
   assign stat.hit         = hit_any;
   assign stat.first       = (k_ff == '0);
   assign stat.last        = (k_ff == KW'(PREFETCH_DEPTH));
   assign stat.fill_rand   = (policy == POL_RANDOM);
   assign stat.fill_scan   = (policy == POL_LRU) || (policy == POL_LFU) || (policy == POL_MRU);
   assign stat.fill_direct = (policy == POL_FIFO) || (policy == POL_LIFO);
   assign stat.scan_end    = (scan_j_ff >= ways_used);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_fills     = rsp_fills_ff;
   assign rsp_hit_total = rsp_total_ff;

endmodule

// ===== hw/rtl/cache_lookup_with_stream_prefetch_top.sv =====
// ----------------------------------------------------------------------------
// cache_lookup_with_stream_prefetch_top
// Set-associative lookup with a sequential stream prefetcher on a miss.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_address
//   rsp     | out       | rsp_valid / rsp_stall | rsp_hit, rsp_fills, rsp_hit_total
//   csr     | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// A hit steps through accept, the remainder steps for the set index, row read,
// compare and hand-off. A miss adds per prefetch address a read, compare and
// step, plus a fill where that address misses, preceded by the remainder steps
// (random) or a scan over the ways in use (LRU, LFU, MRU); the byte-serial
// remainder unit and the scan set the length.
// One access is in work at a time; the next is taken while a result waits.
// Reset is synchronous; no clearing pass is needed, valid bits reset at once.
// ----------------------------------------------------------------------------
module cache_lookup_with_stream_prefetch_top #(
   parameter int unsigned SETS           = clsp_pkg::SETS_DEF,
   parameter int unsigned WAYS           = clsp_pkg::WAYS_DEF,
   parameter int unsigned PREFETCH_DEPTH = clsp_pkg::PREFETCH_DEF,
   parameter int unsigned ADDR_WIDTH     = clsp_pkg::ADDR_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [clsp_pkg::REQ_ADDR_W-1:0]  req_address,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [clsp_pkg::FILLS_W-1:0]     rsp_fills,
   output logic [clsp_pkg::CNT_W-1:0]       rsp_hit_total,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [clsp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [clsp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [clsp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import clsp_pkg::*;

   logic [SET_COUNT_W-1:0] set_count_ff, set_count_in;
   logic [WAY_COUNT_W-1:0] way_count_ff, way_count_in;
   logic [POLICY_W-1:0]    policy_ff, policy_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   csr_wr;
   logic                   cfg_clear;
   clsp_cmd_type           cmd;
   clsp_stat_type          stat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite;

   // any register write rebuilds the cache
   always_comb begin
      set_count_in = set_count_ff;
      way_count_in = way_count_ff;
      policy_in    = policy_ff;
      cfg_clear    = 1'b0;
      prdata       = '0;
      case (reg_idx)
         REG_SET_COUNT: begin
            prdata = CSR_DATA_W'(set_count_ff);
            if (csr_wr) begin
               set_count_in = pwdata[SET_COUNT_W-1:0];
               cfg_clear    = 1'b1;
            end
         end
         REG_WAY_COUNT: begin
            prdata = CSR_DATA_W'(way_count_ff);
            if (csr_wr) begin
               way_count_in = pwdata[WAY_COUNT_W-1:0];
               cfg_clear    = 1'b1;
            end
         end
         REG_POLICY: begin
            prdata = CSR_DATA_W'(policy_ff);
            if (csr_wr) begin
               policy_in = pwdata[POLICY_W-1:0];
               cfg_clear = 1'b1;
            end
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_count_ff <= SET_COUNT_RST;
         way_count_ff <= WAY_COUNT_RST;
         policy_ff    <= POLICY_RST;
      end else begin
         set_count_ff <= set_count_in;
         way_count_ff <= way_count_in;
         policy_ff    <= policy_in;
      end
   end

   clsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   clsp_dp #(
      .SETS           (SETS),
      .WAYS           (WAYS),
      .PREFETCH_DEPTH (PREFETCH_DEPTH),
      .ADDR_WIDTH     (ADDR_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .cfg_clear     (cfg_clear),
      .set_count     (set_count_ff),
      .way_count     (way_count_ff),
      .policy        (policy_ff),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_fills     (rsp_fills),
      .rsp_hit_total (rsp_hit_total)
   );

endmodule

// ===== hw/rtl/clsp_checker.sv =====
// ----------------------------------------------------------------------------
// clsp_checker
// Port-level checks for the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module clsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_hit,
   input logic [clsp_pkg::FILLS_W-1:0]    rsp_fills
);
   import clsp_pkg::*;

   // a held result beat keeps its hit flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("result beat changed while stalled");

   // a demand hit never prefetches
   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_fills == '0)
      else $error("fills reported on a hit");

   // an accepted beat leaves the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken twice in a row");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cache_lookup_with_stream_prefetch_top clsp_checker u_clsp_checker (.*);
